FILE: hw/rtl/bgr_pkg.sv
package bgr_pkg;

    localparam int IDX_W      = 6;
    localparam int VAL_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 3;

    localparam int DEF_AXIS_A_BITS = 4;
    localparam int DEF_AXIS_B_BITS = 6;
    localparam int DEF_AXIS_C_BITS = 4;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_AGG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_AXIS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING_VALUE = 3'd4;

    localparam logic [1:0] AGG_SUM = 2'd0;
    localparam logic [1:0] AGG_MAX = 2'd1;
    localparam logic [1:0] AGG_MIN = 2'd2;

    localparam logic [1:0] AXIS_A    = 2'd0;
    localparam logic [1:0] AXIS_B    = 2'd1;
    localparam logic [1:0] AXIS_C    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [IDX_W-1:0] WIDTH_ONE = 6'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_RMW
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic mem_rd;
        logic mem_wr;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic clr_done;
    } t_dp_status;

endpackage

FILE: hw/rtl/bgr_div.sv
module bgr_div
    import bgr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDX_W-1:0] i_dividend,
    input  logic [IDX_W-1:0] i_divisor,
    output logic [IDX_W-1:0] o_quot,
    output logic [IDX_W-1:0] o_rem,
    output logic             o_done
);

    logic [IDX_W-1:0] r_dvd, n_dvd;
    logic [IDX_W-1:0] r_rem, n_rem;
    logic [IDX_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [IDX_W:0]   rem_shift;
    logic [IDX_W:0]   rem_sub;

    assign rem_shift = {r_rem, r_dvd[IDX_W-1]};
    assign rem_sub   = rem_shift - {1'b0, r_dvs};

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd = i_dividend;
            n_rem = '0;
            n_cnt = CNT_W'(IDX_W);
        end else if (r_cnt != '0) begin
            // restoring step, one quotient bit
            if (!rem_sub[IDX_W]) begin
                n_rem = rem_sub[IDX_W-1:0];
                n_dvd = {r_dvd[IDX_W-2:0], 1'b1};
            end else begin
                n_rem = rem_shift[IDX_W-1:0];
                n_dvd = {r_dvd[IDX_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= (i_divisor == '0) ? WIDTH_ONE : i_divisor;
        end
    end

    assign o_quot = r_dvd;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

FILE: hw/rtl/bgr_datapath.sv
module bgr_datapath
    import bgr_pkg::*;
#(
    parameter int AXIS_A_BITS = DEF_AXIS_A_BITS,
    parameter int AXIS_B_BITS = DEF_AXIS_B_BITS,
    parameter int AXIS_C_BITS = DEF_AXIS_C_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_opcode,
    input  logic [IDX_W-1:0]      i_index_a,
    input  logic [IDX_W-1:0]      i_index_b,
    input  logic [IDX_W-1:0]      i_index_c,
    input  logic [VAL_W-1:0]      i_sample_value,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    output logic                  o_result_valid,
    output logic [VAL_W-1:0]      o_bin_value,
    output logic                  o_bin_empty,
    output logic                  o_saturated
);

    localparam int ADDR_W = AXIS_A_BITS + AXIS_B_BITS + AXIS_C_BITS;
    localparam int NBINS  = 1 << ADDR_W;
    localparam int MEM_W  = VAL_W + 2;

    // configuration
    logic [1:0]       r_agg_mode;
    logic [1:0]       r_bin_axis;
    logic             r_wrap_mode;
    logic [IDX_W-1:0] r_bin_width;
    logic [VAL_W-1:0] r_missing_value;

    // transaction
    logic             r_opcode;
    logic [IDX_W-1:0] r_idx_a, r_idx_b, r_idx_c;
    logic [VAL_W-1:0] r_sample;
    logic [ADDR_W-1:0] r_addr;
    logic             r_in_grid;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [MEM_W-1:0]  r_mem [NBINS];
    logic [MEM_W-1:0]  r_rdata;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_bin_value;
    logic             r_bin_empty;
    logic             r_saturated;

    logic [IDX_W-1:0]  div_dividend;
    logic [IDX_W-1:0]  div_quot, div_rem, div_res;
    logic              div_done;
    logic              div_start;
    logic              need_div;
    logic              in_grid;
    logic [ADDR_W-1:0] addr;

    logic [VAL_W-1:0]  rd_val;
    logic              rd_valid, rd_sat;
    logic signed [VAL_W:0] sum;
    logic [VAL_W-1:0]  acc_val;
    logic              acc_sat;
    logic              wr_ok;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata, rmw_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agg_mode      <= AGG_SUM;
            r_bin_axis      <= AXIS_B;
            r_wrap_mode     <= 1'b0;
            r_bin_width     <= WIDTH_ONE;
            r_missing_value <= VAL_MIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_AGG_MODE:      r_agg_mode      <= i_cfg_wdata[1:0];
                CFG_BIN_AXIS:      r_bin_axis      <= i_cfg_wdata[1:0];
                CFG_WRAP_MODE:     r_wrap_mode     <= i_cfg_wdata[0];
                CFG_BIN_WIDTH:     r_bin_width     <= i_cfg_wdata[IDX_W-1:0];
                CFG_MISSING_VALUE: r_missing_value <= i_cfg_wdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_bin_axis)
            AXIS_A:  div_dividend = i_index_a;
            AXIS_B:  div_dividend = i_index_b;
            default: div_dividend = i_index_c;
        endcase
    end

    assign need_div  = (i_opcode == OP_ACC) && (r_bin_axis inside {AXIS_A, AXIS_B, AXIS_C});
    assign div_start = i_cmd.load && need_div;

    bgr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_bin_width),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_done     (div_done)
    );

    assign div_res = r_wrap_mode ? div_rem : div_quot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_idx_a  <= i_index_a;
            r_idx_b  <= i_index_b;
            r_idx_c  <= i_index_c;
            r_sample <= i_sample_value;
        end else if (div_done) begin
            case (r_bin_axis)
                AXIS_A:  r_idx_a <= div_res;
                AXIS_B:  r_idx_b <= div_res;
                AXIS_C:  r_idx_c <= div_res;
                default: ;
            endcase
        end
    end

    assign in_grid = ((r_idx_a >> AXIS_A_BITS) == '0) &&
                     ((r_idx_b >> AXIS_B_BITS) == '0) &&
                     ((r_idx_c >> AXIS_C_BITS) == '0);
    assign addr = {r_idx_a[AXIS_A_BITS-1:0], r_idx_b[AXIS_B_BITS-1:0],
                   r_idx_c[AXIS_C_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_addr    <= addr;
            r_in_grid <= in_grid;
        end
    end

    // read-modify-write
    assign rd_val   = r_rdata[VAL_W-1:0];
    assign rd_valid = r_rdata[VAL_W];
    assign rd_sat   = r_rdata[VAL_W+1];
    assign sum      = $signed({rd_val[VAL_W-1], rd_val}) + $signed({r_sample[VAL_W-1], r_sample});

    always_comb begin
        acc_sat = rd_sat;
        case (r_agg_mode)
            AGG_SUM: begin
                if (sum[VAL_W] != sum[VAL_W-1]) begin
                    acc_val = sum[VAL_W] ? VAL_MIN : VAL_MAX;
                    acc_sat = 1'b1;
                end else begin
                    acc_val = sum[VAL_W-1:0];
                end
            end
            AGG_MAX: acc_val = ($signed(r_sample) > $signed(rd_val)) ? r_sample : rd_val;
            AGG_MIN: acc_val = ($signed(r_sample) < $signed(rd_val)) ? r_sample : rd_val;
            default: acc_val = rd_val;
        endcase
    end

    always_comb begin
        if (r_opcode == OP_READ) begin
            rmw_wdata = '0;
        end else if (!rd_valid) begin
            rmw_wdata = {rd_sat, 1'b1, r_sample};
        end else begin
            rmw_wdata = {acc_sat, 1'b1, acc_val};
        end
    end

    assign wr_ok     = r_in_grid && ((r_opcode == OP_READ) || (r_sample != r_missing_value));
    assign mem_we    = i_cmd.clr_wr || (i_cmd.mem_wr && wr_ok);
    assign mem_waddr = i_cmd.clr_wr ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clr_wr ? '0 : rmw_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.mem_wr && (r_opcode == OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_bin_value <= (r_in_grid && rd_valid) ? rd_val : r_missing_value;
            r_bin_empty <= !(r_in_grid && rd_valid);
            r_saturated <= r_in_grid && rd_sat;
        end
    end

    assign o_status.need_div = need_div;
    assign o_status.div_done = div_done;
    assign o_status.clr_done = (r_clr_addr == '1);

    assign o_result_valid = r_out_valid;
    assign o_bin_value    = r_bin_value;
    assign o_bin_empty    = r_bin_empty;
    assign o_saturated    = r_saturated;

endmodule

FILE: hw/rtl/bgr_ctrl.sv
module bgr_ctrl
    import bgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_status.need_div ? S_DIV : S_ADDR;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR:  n_state = S_RMW;
            S_RMW:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_ADDR:  o_cmd.mem_rd = 1'b1;
            S_RMW:   o_cmd.mem_wr = 1'b1;
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_rmw_after_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> ($past(r_state) == S_ADDR))
        else $error("read-modify-write without address cycle");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && ($past(r_state) == S_CLEAR)) |-> $past(i_status.clr_done))
        else $error("left clearing pass early");

    a_no_mem_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> (!o_cmd.mem_rd && !o_cmd.mem_wr && !o_cmd.clr_wr))
        else $error("memory access while idle");
`endif

endmodule

FILE: hw/rtl/binned_grid_reduction_unit.sv
// channel     direction  handshake                 payload
// command     in         i_start, o_busy           i_opcode, i_index_a/b/c, i_sample_value
// result      out        o_result_valid (strobe)   o_bin_value, o_bin_empty, o_saturated
// config      in         i_cfg_wr_en               i_cfg_index, i_cfg_wdata
//
// a transaction is taken when i_start is high and o_busy is low
// read: accept, address, read-modify-write; result strobed the cycle after
// accumulate: accept, the 6-step iterative divider, address, read-modify-write
// accumulate with no binned axis: steps as a read, with no divide
// after reset a clearing pass writes every bin once, busy throughout
// the result strobe lasts one cycle and cannot be stalled
module binned_grid_reduction_unit
    import bgr_pkg::*;
#(
    parameter int AXIS_A_BITS = DEF_AXIS_A_BITS,
    parameter int AXIS_B_BITS = DEF_AXIS_B_BITS,
    parameter int AXIS_C_BITS = DEF_AXIS_C_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_opcode,
    input  logic [IDX_W-1:0]      i_index_a,
    input  logic [IDX_W-1:0]      i_index_b,
    input  logic [IDX_W-1:0]      i_index_c,
    input  logic [VAL_W-1:0]      i_sample_value,
    output logic                  o_result_valid,
    output logic [VAL_W-1:0]      o_bin_value,
    output logic                  o_bin_empty,
    output logic                  o_saturated,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    bgr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    bgr_datapath #(
        .AXIS_A_BITS (AXIS_A_BITS),
        .AXIS_B_BITS (AXIS_B_BITS),
        .AXIS_C_BITS (AXIS_C_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_opcode),
        .i_index_a      (i_index_a),
        .i_index_b      (i_index_b),
        .i_index_c      (i_index_c),
        .i_sample_value (i_sample_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_bin_value    (o_bin_value),
        .o_bin_empty    (o_bin_empty),
        .o_saturated    (o_saturated)
    );

endmodule
